[hw/rtl/owfs_pkg.sv]
// ----------------------------------------------------------------------------
// owfs_pkg
// Request and response types, command codes, status codes and slot states
// shared by the frame slot store.
// ----------------------------------------------------------------------------
package owfs_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  localparam logic [1:0] STS_DONE      = 2'd0;
  localparam logic [1:0] STS_OVERWROTE = 2'd1;
  localparam logic [1:0] STS_NO_UNREAD = 2'd2;
  localparam logic [1:0] STS_DROPPED   = 2'd3;

  localparam logic [1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [1:0] SLOT_UNREAD  = 2'd1;
  localparam logic [1:0] SLOT_READING = 2'd2;

  localparam int STAMP_WIDTH = 32;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] frame_value;
    logic [2:0]         slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         slot_used;
    logic signed [31:0] read_value;
    logic [31:0]        read_stamp;
  } rsp_t;

endpackage

[hw/rtl/owfs_ram.sv]
// ----------------------------------------------------------------------------
// owfs_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module owfs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/overwrite_oldest_frame_slots.sv]
// ----------------------------------------------------------------------------
// overwrite_oldest_frame_slots
// Frame slot store that overwrites the oldest unread frame when it is full.
// ----------------------------------------------------------------------------
// A write request goes to the lowest empty slot, or else replaces the oldest
// unread frame; a begin-read request claims the oldest unread frame and an
// end-read request frees a slot. One request is handled at a time. A write
// that finds an empty slot, an end-read and an unused command go from
// acceptance straight to S_DONE. A write into a full store and a begin-read
// first search for the oldest unread frame, which reads one stamp per cycle
// from the slot memory through a single age comparator in S_SCAN; a
// begin-read that claims a frame then reads it out in S_FETCH. A finished
// response waits in the output register while the next request is accepted.
module overwrite_oldest_frame_slots #(
  parameter int SLOT_COUNT = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  owfs_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output owfs_pkg::rsp_t rsp
);

  import owfs_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int RAM_W  = STAMP_WIDTH + DATA_WIDTH;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_FETCH,
    S_DONE
  } state_t;

  state_t                 state;
  req_t                   cur;
  rsp_t                   res;
  logic [1:0]             slot_state [SLOT_COUNT];
  logic [31:0]            seq;
  logic [SLOT_W:0]        scan_cnt;
  logic                   rd_vld;
  logic [SLOT_W-1:0]      rd_idx;
  logic                   found;
  logic [SLOT_W-1:0]      best_idx;
  logic [31:0]            best_age;

  logic                   empty_any;
  logic [SLOT_W-1:0]      empty_idx;
  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr;
  logic [RAM_W-1:0]       ram_wdata;
  logic [SLOT_W-1:0]      ram_raddr;
  logic [RAM_W-1:0]       ram_rdata;
  logic signed [31:0]     wr_value;
  logic [63:0]            wr_wide;
  logic [31:0]            age;

  function automatic logic [2:0] used3(logic [SLOT_W-1:0] i);
    logic [SLOT_W+2:0] w;
    w = {3'b000, i};
    return w[2:0];
  endfunction

  function automatic logic [31:0] widen(logic [DATA_WIDTH-1:0] d);
    logic [DATA_WIDTH+63:0] w;
    w = {{64{d[DATA_WIDTH-1]}}, d};
    return w[31:0];
  endfunction

  always_comb begin
    empty_any = 1'b0;
    empty_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (slot_state[i] == SLOT_EMPTY) begin
        empty_any = 1'b1;
        empty_idx = SLOT_W'(i);
      end
    end
  end

  assign wr_value  = (state == S_IDLE) ? req.frame_value : cur.frame_value;
  assign wr_wide   = {{32{wr_value[31]}}, wr_value};
  assign age       = seq - ram_rdata[DATA_WIDTH +: STAMP_WIDTH];
  assign req_ready = (state == S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = empty_idx;
    ram_wdata = {seq, wr_wide[DATA_WIDTH-1:0]};
    ram_raddr = scan_cnt[SLOT_W-1:0];
    if (state == S_IDLE) begin
      ram_we = req_valid && (req.cmd == CMD_WRITE) && empty_any;
    end else if (state == S_ACT) begin
      ram_we    = found && (cur.cmd == CMD_WRITE);
      ram_waddr = best_idx;
      ram_raddr = best_idx;
    end
  end

  owfs_ram #(
    .WIDTH(RAM_W),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seq       <= 32'd1;
      rsp_valid <= 1'b0;
      rd_vld    <= 1'b0;
      found     <= 1'b0;
      scan_cnt  <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_state[i] <= SLOT_EMPTY;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur <= req;
            unique case (req.cmd)
              CMD_WRITE: begin
                if (empty_any) begin
                  slot_state[empty_idx] <= SLOT_UNREAD;
                  seq   <= seq + 32'd1;
                  res   <= '{STS_DONE, used3(empty_idx), 32'sd0, 32'd0};
                  state <= S_DONE;
                end else begin
                  found    <= 1'b0;
                  scan_cnt <= '0;
                  rd_vld   <= 1'b0;
                  state    <= S_SCAN;
                end
              end
              CMD_READ: begin
                found    <= 1'b0;
                scan_cnt <= '0;
                rd_vld   <= 1'b0;
                state    <= S_SCAN;
              end
              CMD_END: begin
                if (int'(req.slot_index) < SLOT_COUNT) begin
                  slot_state[SLOT_W'(req.slot_index)] <= SLOT_EMPTY;
                end
                res   <= '{STS_DONE, req.slot_index, 32'sd0, 32'd0};
                state <= S_DONE;
              end
              default: begin
                res   <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          rd_vld <= (int'(scan_cnt) < SLOT_COUNT);
          rd_idx <= scan_cnt[SLOT_W-1:0];
          if (int'(scan_cnt) < SLOT_COUNT) begin
            scan_cnt <= scan_cnt + 1'b1;
          end
          if (rd_vld && (slot_state[rd_idx] == SLOT_UNREAD) &&
              (!found || (age > best_age))) begin
            found    <= 1'b1;
            best_idx <= rd_idx;
            best_age <= age;
          end
          if (rd_vld && (rd_idx == LAST_SLOT)) begin
            state <= S_ACT;
          end
        end
        S_ACT: begin
          if (!found) begin
            res   <= '{(cur.cmd == CMD_WRITE) ? STS_DROPPED : STS_NO_UNREAD,
                       3'd0, 32'sd0, 32'd0};
            state <= S_DONE;
          end else if (cur.cmd == CMD_WRITE) begin
            slot_state[best_idx] <= SLOT_UNREAD;
            seq   <= seq + 32'd1;
            res   <= '{STS_OVERWROTE, used3(best_idx), 32'sd0, 32'd0};
            state <= S_DONE;
          end else begin
            slot_state[best_idx] <= SLOT_READING;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          res   <= '{STS_DONE, used3(best_idx),
                     widen(ram_rdata[DATA_WIDTH-1:0]),
                     ram_rdata[DATA_WIDTH +: STAMP_WIDTH]};
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            state <= S_IDLE;
          end
        end
      endcase

      if ((state == S_DONE) && (!rsp_valid || rsp_ready)) begin
        rsp       <= res;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
